[hdl/psarl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_pkg
// Shared types and constants of the per-source admission rate limiter:
// table geometry, opcodes, decision codes, register indexes and the layout
// of one source table row.
// ----------------------------------------------------------------------------
package psarl_pkg;

   // table geometry and field widths
   localparam int TABLE_ENTRIES = 64;
   localparam int TIME_BITS     = 48;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int TOK_BITS      = 48;
   localparam int SESS_BITS     = 16;
   localparam int COUNT_BITS    = 16;
   localparam int PERIOD_BITS   = 32;
   localparam int TRACK_BITS    = 7;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   // operation codes
   typedef enum logic [1:0] {
      OP_ADMIT        = 2'd0,
      OP_RELEASE      = 2'd1,
      OP_DENIED_AUTH  = 2'd2,
      OP_EXHAUST_AUTH = 2'd3
   } op_type;

   // decision codes
   typedef enum logic [2:0] {
      DEC_ALLOWED    = 3'd0,
      DEC_GLOBAL     = 3'd1,
      DEC_TABLE_FULL = 3'd2,
      DEC_CONN_RATE  = 3'd3,
      DEC_AUTH_RATE  = 3'd4,
      DEC_PER_SOURCE = 3'd5
   } dec_type;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_SESSIONS     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_PER_SOURCE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TRACKED      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONN_RATE_COUNT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONN_RATE_PERIOD = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AUTH_RATE_COUNT  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AUTH_RATE_PERIOD = 3'd6;

   // source key
   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic        key_is_v6;
      logic [31:0] key_scope;
   } key_type;

   // one table row
   typedef struct packed {
      key_type                key;
      logic [SESS_BITS-1:0]   sessions;
      logic [TIME_BITS-1:0]   seen_tick;
      logic [TOK_BITS-1:0]    conn_tok;
      logic [TIME_BITS-1:0]   conn_upd;
      logic [TOK_BITS-1:0]    auth_tok;
      logic [TIME_BITS-1:0]   auth_upd;
   } row_type;

   localparam int ROW_BITS = $bits(row_type);

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_run;
      logic cap;
      logic resolve;
      logic elapsed;
      logic multiply;
      logic refill;
      logic apply;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic bucket_path;
   } dp_status_type;

endpackage
`default_nettype wire

[hdl/psarl_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_req_if
// Request channel: one operation on one source address.
// ----------------------------------------------------------------------------
interface psarl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic        addr_is_v6;
   logic [31:0] scope_tag;
   logic [psarl_pkg::TIME_BITS-1:0] now_tick;

   modport source (output valid, opcode, addr_high, addr_low, addr_is_v6, scope_tag,
                   now_tick, input ready);
   modport sink   (input valid, opcode, addr_high, addr_low, addr_is_v6, scope_tag,
                   now_tick, output ready);
endinterface
`default_nettype wire

[hdl/psarl_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_rsp_if
// Response channel: decision code and whether the source is tracked.
// ----------------------------------------------------------------------------
interface psarl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] decision;
   logic       source_known;

   modport source (output valid, decision, source_known, input ready);
   modport sink   (input valid, decision, source_known, output ready);
endinterface
`default_nettype wire

[hdl/psarl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psarl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[hdl/psarl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_ctrl
// Sequencer: accepts a request, walks the table scan, resolution, bucket
// refill and commit steps, and owns the response valid flag.
// ----------------------------------------------------------------------------
module psarl_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      psarl_pkg::dp_cmd_type    cmd,
   input  wire psarl_pkg::dp_status_type status
);
   import psarl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_CAP, ST_RESOLVE, ST_ELAPSED, ST_MUL, ST_REFILL, ST_APPLY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // result slot is free once the previous transaction has gone
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // commands
   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_run = (state_ff == ST_SCAN);
      cmd.cap      = (state_ff == ST_CAP);
      cmd.resolve  = (state_ff == ST_RESOLVE);
      cmd.elapsed  = (state_ff == ST_ELAPSED);
      cmd.multiply = (state_ff == ST_MUL);
      cmd.refill   = (state_ff == ST_REFILL);
      cmd.apply    = (state_ff == ST_APPLY) && slot_free;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_CAP;
         end
         ST_CAP:     state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = status.bucket_path ? ST_ELAPSED : ST_APPLY;
         ST_ELAPSED: state_in = ST_MUL;
         ST_MUL:     state_in = ST_REFILL;
         ST_REFILL:  state_in = ST_APPLY;
         ST_APPLY: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

[hdl/psarl_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_dp
// Datapath: configuration registers, source table (valid bits in flops, rows
// in RAM), scan accumulators, token bucket arithmetic and result registers.
// ----------------------------------------------------------------------------
module psarl_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [psarl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [psarl_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic [63:0]                         req_addr_high,
   input  wire logic [63:0]                         req_addr_low,
   input  wire logic                                req_addr_is_v6,
   input  wire logic [31:0]                         req_scope_tag,
   input  wire logic [psarl_pkg::TIME_BITS-1:0]     req_now_tick,
   input  wire psarl_pkg::dp_cmd_type               cmd,
   output      psarl_pkg::dp_status_type            status,
   output      logic [2:0]                          rsp_decision,
   output      logic                                rsp_source_known
);
   import psarl_pkg::*;

   typedef struct packed {
      logic [TOK_BITS-1:0]  tok;
      logic [TIME_BITS-1:0] upd;
   } bucket_type;

   // configuration
   logic [SESS_BITS-1:0]   max_sessions_ff;
   logic [SESS_BITS-1:0]   max_per_source_ff;
   logic [TRACK_BITS-1:0]  max_tracked_ff;
   logic [COUNT_BITS-1:0]  conn_count_ff;
   logic [PERIOD_BITS-1:0] conn_period_ff;
   logic [COUNT_BITS-1:0]  auth_count_ff;
   logic [PERIOD_BITS-1:0] auth_period_ff;

   // current transaction
   op_type               op_ff;
   key_type              key_ff;
   logic [TIME_BITS-1:0] now_ff;

   // table state
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [SESS_BITS-1:0]     total_ff;

   // scan
   logic [CNT_BITS-1:0]      scan_cnt_ff;
   logic                     rd_pend_ff;
   logic [IDX_BITS-1:0]      rd_idx_ff;
   logic                     found_ff;
   logic [IDX_BITS-1:0]      match_idx_ff;
   row_type                  match_row_ff;
   logic [CNT_BITS-1:0]      valid_cnt_ff;
   logic [CNT_BITS-1:0]      idle_cnt_ff;
   logic                     free_found_ff;
   logic [IDX_BITS-1:0]      free_idx_ff;
   logic                     pfree_found_ff;
   logic [IDX_BITS-1:0]      pfree_idx_ff;
   logic [TABLE_ENTRIES-1:0] idle_mask_ff;

   // bucket working registers
   logic [TOK_BITS-1:0]  ccap_ff, acap_ff;
   logic [IDX_BITS-1:0]  entry_idx_ff;
   logic                 write_row_ff;
   dec_type              early_dec_ff;
   row_type              ent_ff;
   logic [TIME_BITS-1:0] cel_ff, ael_ff;
   logic                 clate_ff, alate_ff;
   logic [TOK_BITS-1:0]  cprod_ff, aprod_ff;
   bucket_type           cref_ff, aref_ff;

   // result
   dec_type dec_out_ff;
   logic    known_out_ff;

   // combinational
   logic [PERIOD_BITS-1:0] cp, ap, retention;
   logic [CNT_BITS-1:0]    limit;
   logic                   rd_en;
   row_type                rd_row, init_row, fin_row;
   logic                   rd_vld, hit, idle;
   logic [TIME_BITS:0]     idle_diff;
   logic                   is_admit, total_full, need_prune, can_insert, bucket_path;
   logic [CNT_BITS-1:0]    cnt_after;
   logic [TIME_BITS:0]     cdiff, adiff;
   dec_type                fin_dec;
   logic                   total_inc, total_dec;
   bucket_type             cref_in, aref_in;
   logic [ROW_BITS-1:0]    rd_data;

   // bucket refill: saturates at count * period, full after one whole period
   function automatic bucket_type refill(input bucket_type b, input logic late,
                                         input logic [TIME_BITS-1:0] el,
                                         input logic [TOK_BITS-1:0] prod,
                                         input logic [TOK_BITS-1:0] cap,
                                         input logic [PERIOD_BITS-1:0] period,
                                         input logic [TIME_BITS-1:0] now);
      bucket_type       r;
      logic [TOK_BITS:0] sum;
      r   = b;
      sum = {1'b0, b.tok} + {1'b0, prod};
      if (late) begin
         if (el >= TIME_BITS'(period)) r.tok = cap;
         else if (sum > {1'b0, cap}) r.tok = cap;
         else r.tok = sum[TOK_BITS-1:0];
         r.upd = now;
      end
      return r;
   endfunction

   // effective periods, idle retention and table limit
   assign cp        = (conn_period_ff == '0) ? PERIOD_BITS'(1) : conn_period_ff;
   assign ap        = (auth_period_ff == '0) ? PERIOD_BITS'(1) : auth_period_ff;
   assign retention = (cp > ap) ? cp : ap;
   assign limit     = (32'(max_tracked_ff) > 32'(TABLE_ENTRIES)) ?
                      CNT_BITS'(TABLE_ENTRIES) : CNT_BITS'(max_tracked_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_sessions_ff   <= SESS_BITS'(64);
         max_per_source_ff <= SESS_BITS'(4);
         max_tracked_ff    <= TRACK_BITS'(64);
         conn_count_ff     <= COUNT_BITS'(10);
         conn_period_ff    <= PERIOD_BITS'(1000000);
         auth_count_ff     <= COUNT_BITS'(5);
         auth_period_ff    <= PERIOD_BITS'(1000000);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_SESSIONS:     max_sessions_ff   <= csr_write_data[SESS_BITS-1:0];
            CSR_MAX_PER_SOURCE:   max_per_source_ff <= csr_write_data[SESS_BITS-1:0];
            CSR_MAX_TRACKED:      max_tracked_ff    <= csr_write_data[TRACK_BITS-1:0];
            CSR_CONN_RATE_COUNT:  conn_count_ff     <= csr_write_data[COUNT_BITS-1:0];
            CSR_CONN_RATE_PERIOD: conn_period_ff    <= csr_write_data[PERIOD_BITS-1:0];
            CSR_AUTH_RATE_COUNT:  auth_count_ff     <= csr_write_data[COUNT_BITS-1:0];
            CSR_AUTH_RATE_PERIOD: auth_period_ff    <= csr_write_data[PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // row storage
   assign rd_en = cmd.scan_run && (scan_cnt_ff < CNT_BITS'(TABLE_ENTRIES));

   psarl_ram #(.WIDTH(ROW_BITS), .DEPTH(TABLE_ENTRIES)) u_rows (
      .clock   (clock),
      .wr_en   (cmd.apply && write_row_ff),
      .wr_addr (entry_idx_ff),
      .wr_data (fin_row),
      .rd_en   (rd_en),
      .rd_addr (scan_cnt_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   // per-entry checks on the row coming out of the RAM
   always_comb begin
      rd_row    = row_type'(rd_data);
      rd_vld    = rd_pend_ff && valid_ff[rd_idx_ff];
      hit       = rd_vld && (rd_row.key == key_ff);
      idle_diff = {1'b0, now_ff} - {1'b0, rd_row.seen_tick};
      idle      = rd_vld && (rd_row.sessions == '0) && !idle_diff[TIME_BITS] &&
                  (idle_diff[TIME_BITS-1:0] >= TIME_BITS'(retention));
   end

   // outcome of the scan
   always_comb begin
      is_admit    = (op_ff == OP_ADMIT);
      total_full  = (total_ff >= max_sessions_ff);
      need_prune  = (valid_cnt_ff >= limit);
      cnt_after   = need_prune ? (valid_cnt_ff - idle_cnt_ff) : valid_cnt_ff;
      can_insert  = is_admit && !found_ff && !total_full && (cnt_after < limit);
      bucket_path = found_ff || can_insert;
   end

   assign status.scan_done   = (scan_cnt_ff == CNT_BITS'(TABLE_ENTRIES)) && !rd_pend_ff;
   assign status.bucket_path = bucket_path;

   // fresh entry: both buckets full, no sessions, times at now
   always_comb begin
      init_row           = '0;
      init_row.key       = key_ff;
      init_row.seen_tick = now_ff;
      init_row.conn_tok  = ccap_ff;
      init_row.conn_upd  = now_ff;
      init_row.auth_tok  = acap_ff;
      init_row.auth_upd  = now_ff;
   end

   // elapsed times and refills
   assign cdiff   = {1'b0, now_ff} - {1'b0, ent_ff.conn_upd};
   assign adiff   = {1'b0, now_ff} - {1'b0, ent_ff.auth_upd};
   assign cref_in = refill('{tok: ent_ff.conn_tok, upd: ent_ff.conn_upd}, clate_ff, cel_ff,
                           cprod_ff, ccap_ff, cp, now_ff);
   assign aref_in = refill('{tok: ent_ff.auth_tok, upd: ent_ff.auth_upd}, alate_ff, ael_ff,
                           aprod_ff, acap_ff, ap, now_ff);

   // final row and decision
   always_comb begin
      fin_row   = ent_ff;
      fin_dec   = DEC_ALLOWED;
      total_inc = 1'b0;
      total_dec = 1'b0;
      case (op_ff)
         OP_ADMIT: begin
            fin_row.seen_tick = now_ff;
            fin_row.conn_upd  = cref_ff.upd;
            if (cref_ff.tok < TOK_BITS'(cp)) begin
               fin_dec          = DEC_CONN_RATE;
               fin_row.conn_tok = cref_ff.tok;
            end else begin
               fin_row.conn_tok = cref_ff.tok - TOK_BITS'(cp);
               fin_row.auth_tok = aref_ff.tok;
               fin_row.auth_upd = aref_ff.upd;
               if (aref_ff.tok < TOK_BITS'(ap)) begin
                  fin_dec = DEC_AUTH_RATE;
               end else if (total_full) begin
                  fin_dec = DEC_GLOBAL;
               end else if (ent_ff.sessions >= max_per_source_ff) begin
                  fin_dec = DEC_PER_SOURCE;
               end else begin
                  fin_row.sessions = ent_ff.sessions + SESS_BITS'(1);
                  total_inc        = 1'b1;
               end
            end
         end
         OP_RELEASE: begin
            if (ent_ff.sessions != '0) begin
               fin_row.sessions  = ent_ff.sessions - SESS_BITS'(1);
               fin_row.seen_tick = now_ff;
               total_dec         = (total_ff != '0);
            end
         end
         OP_DENIED_AUTH: begin
            fin_row.seen_tick = now_ff;
            fin_row.auth_upd  = aref_ff.upd;
            fin_row.auth_tok  = (aref_ff.tok >= TOK_BITS'(ap)) ?
                                (aref_ff.tok - TOK_BITS'(ap)) : '0;
         end
         OP_EXHAUST_AUTH: begin
            fin_row.seen_tick = now_ff;
            fin_row.auth_upd  = aref_ff.upd;
            fin_row.auth_tok  = '0;
         end
         default: ;
      endcase
   end

   // control state: table valid bits, session total, scan sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         total_ff    <= '0;
         scan_cnt_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
         if (cmd.load) begin
            scan_cnt_ff <= '0;
         end else if (rd_en) begin
            scan_cnt_ff <= scan_cnt_ff + CNT_BITS'(1);
         end
         // idle entries go only when a new source needs room
         if (cmd.resolve && is_admit && !found_ff && !total_full && need_prune) begin
            valid_ff <= valid_ff & ~idle_mask_ff;
         end
         if (cmd.apply && write_row_ff) begin
            valid_ff[entry_idx_ff] <= 1'b1;
            if (total_inc) total_ff <= total_ff + SESS_BITS'(1);
            else if (total_dec) total_ff <= total_ff - SESS_BITS'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff                <= op_type'(req_opcode);
         key_ff.key_high      <= req_addr_is_v6 ? req_addr_high : '0;
         key_ff.key_low       <= req_addr_is_v6 ? req_addr_low : {32'd0, req_addr_low[31:0]};
         key_ff.key_is_v6     <= req_addr_is_v6;
         key_ff.key_scope     <= req_addr_is_v6 ? req_scope_tag : '0;
         now_ff               <= req_now_tick;
         found_ff             <= 1'b0;
         valid_cnt_ff         <= '0;
         idle_cnt_ff          <= '0;
         free_found_ff        <= 1'b0;
         pfree_found_ff       <= 1'b0;
      end
      // scan accumulation, one entry a cycle
      if (rd_pend_ff) begin
         idle_mask_ff[rd_idx_ff] <= idle;
         if (rd_vld) valid_cnt_ff <= valid_cnt_ff + CNT_BITS'(1);
         if (idle) idle_cnt_ff <= idle_cnt_ff + CNT_BITS'(1);
         if (hit && !found_ff) begin
            found_ff     <= 1'b1;
            match_idx_ff <= rd_idx_ff;
            match_row_ff <= rd_row;
         end
         if (!rd_vld && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
         if ((!rd_vld || idle) && !pfree_found_ff) begin
            pfree_found_ff <= 1'b1;
            pfree_idx_ff   <= rd_idx_ff;
         end
      end
      if (rd_en) rd_idx_ff <= scan_cnt_ff[IDX_BITS-1:0];
      // bucket capacities
      if (cmd.cap) begin
         ccap_ff <= TOK_BITS'(conn_count_ff) * TOK_BITS'(cp);
         acap_ff <= TOK_BITS'(auth_count_ff) * TOK_BITS'(ap);
      end
      // pick or create the entry
      if (cmd.resolve) begin
         write_row_ff <= bucket_path;
         early_dec_ff <= (is_admit && !found_ff) ?
                         (total_full ? DEC_GLOBAL : DEC_TABLE_FULL) : DEC_ALLOWED;
         entry_idx_ff <= found_ff ? match_idx_ff : (need_prune ? pfree_idx_ff : free_idx_ff);
         ent_ff       <= found_ff ? match_row_ff : init_row;
      end
      if (cmd.elapsed) begin
         clate_ff <= !cdiff[TIME_BITS] && (cdiff[TIME_BITS-1:0] != '0);
         alate_ff <= !adiff[TIME_BITS] && (adiff[TIME_BITS-1:0] != '0);
         cel_ff   <= cdiff[TIME_BITS-1:0];
         ael_ff   <= adiff[TIME_BITS-1:0];
      end
      if (cmd.multiply) begin
         cprod_ff <= TOK_BITS'(cel_ff[PERIOD_BITS-1:0]) * TOK_BITS'(conn_count_ff);
         aprod_ff <= TOK_BITS'(ael_ff[PERIOD_BITS-1:0]) * TOK_BITS'(auth_count_ff);
      end
      if (cmd.refill) begin
         cref_ff <= cref_in;
         aref_ff <= aref_in;
      end
      // result register
      if (cmd.apply) begin
         dec_out_ff   <= write_row_ff ? fin_dec : early_dec_ff;
         known_out_ff <= write_row_ff;
      end
   end

   assign rsp_decision     = dec_out_ff;
   assign rsp_source_known = known_out_ff;
endmodule
`default_nettype wire

[hdl/per_source_admission_rate_limiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_admission_rate_limiter
// Per-source admission control: associative table of source addresses, each
// with connection and auth token buckets and an open-session count.
//
//   channel  direction  handshake          payload
//   req_     in         valid / ready      opcode, address, scope, now_tick
//   rsp_     out        valid / ready      decision, source_known
//   csr_     in         write enable only  index, write data
//
// A transaction sweeps the table through the single RAM read port, one entry
// a cycle, and drains the last read; then come capacity, resolve, three
// bucket steps (elapsed, multiply, refill) and commit. With no bucket to
// touch, resolve goes straight to commit and the bucket steps are skipped.
// One transaction is in flight at a time; the next may be accepted while the
// previous result still waits in the output register, and commit stalls
// until that register is free.
// Synchronous active-high reset empties the table and zeroes the session total.
// ----------------------------------------------------------------------------
module per_source_admission_rate_limiter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   psarl_req_if.sink                                req_chan,
   psarl_rsp_if.source                              rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [psarl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [psarl_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import psarl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   psarl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // table and arithmetic
   psarl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_opcode       (req_chan.opcode),
      .req_addr_high    (req_chan.addr_high),
      .req_addr_low     (req_chan.addr_low),
      .req_addr_is_v6   (req_chan.addr_is_v6),
      .req_scope_tag    (req_chan.scope_tag),
      .req_now_tick     (req_chan.now_tick),
      .cmd              (cmd),
      .status           (status),
      .rsp_decision     (rsp_chan.decision),
      .rsp_source_known (rsp_chan.source_known)
   );
endmodule
`default_nettype wire

[hdl/psarl_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psarl_checker
// Port-level checks on the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module psarl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_decision,
   input wire logic       rsp_source_known
);
   import psarl_pkg::*;

   // a pending result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // decision code in range
   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decision <= DEC_PER_SOURCE))
      else $error("decision code out of range");

   // rate and per-source denials only ever concern a tracked source
   a_known_on_rate_deny: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_decision == DEC_CONN_RATE || rsp_decision == DEC_AUTH_RATE ||
                     rsp_decision == DEC_PER_SOURCE)) |-> rsp_source_known)
      else $error("rate denial for an untracked source");

   // nothing offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind per_source_admission_rate_limiter psarl_checker u_psarl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_decision     (rsp_chan.decision),
   .rsp_source_known (rsp_chan.source_known)
);
`default_nettype wire

[dv/tb_per_source_admission_rate_limiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_per_source_admission_rate_limiter
// Self-checking bench for the per-source admission rate limiter. A scoreboard
// model of the source table and token buckets predicts the decision of every
// accepted request transaction. Responses are compared in order. Stimulus is
// a directed part and then several random phases, each with its own register
// settings, with random idling on both channels except in the last phase.
// ----------------------------------------------------------------------------
module tb_per_source_admission_rate_limiter;
   import psarl_pkg::*;

   typedef struct packed {
      op_type      opcode;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic        addr_is_v6;
      logic [31:0] scope_tag;
      logic [47:0] now_tick;
   } req_type;

   typedef struct packed {
      logic [2:0] decision;
      logic       source_known;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   psarl_req_if req_chan ();
   psarl_rsp_if rsp_chan ();

   per_source_admission_rate_limiter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [63:0] m_max_sess, m_max_per_src, m_max_track;
   logic [63:0] m_conn_cnt, m_conn_per, m_auth_cnt, m_auth_per;
   logic        t_valid [TABLE_ENTRIES];
   req_type     t_key [TABLE_ENTRIES];
   logic [63:0] t_sess [TABLE_ENTRIES];
   logic [63:0] t_seen [TABLE_ENTRIES];
   logic [63:0] t_ctok [TABLE_ENTRIES];
   logic [63:0] t_cupd [TABLE_ENTRIES];
   logic [63:0] t_atok [TABLE_ENTRIES];
   logic [63:0] t_aupd [TABLE_ENTRIES];
   logic [63:0] m_total;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      error_count = 0;
   bit      idle_enable = 1'b1;
   bit      req_fired = 1'b0;
   int      tx_gap = 0;
   int      rx_gap = 0;

   // recently used addresses, so that random traffic hits known sources
   req_type addr_pool[$];

   task automatic model_reset();
      m_max_sess = 64; m_max_per_src = 4; m_max_track = 64;
      m_conn_cnt = 10; m_conn_per = 1000000;
      m_auth_cnt = 5;  m_auth_per = 1000000;
      m_total = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) t_valid[i] = 1'b0;
   endtask

   function automatic logic [63:0] eff_per(logic [63:0] p);
      return (p == 0) ? 64'd1 : p;
   endfunction

   function automatic void refill_bucket(inout logic [63:0] tok, inout logic [63:0] upd,
                                         input logic [63:0] cnt, input logic [63:0] per,
                                         input logic [63:0] now);
      logic [63:0] cap, el, t;
      cap = cnt * per;
      if (now > upd) begin
         el = now - upd;
         if (el >= per) t = cap;
         else begin
            t = tok + el * cnt;
            if (t > cap) t = cap;
         end
         tok = t & 64'hFFFF_FFFF_FFFF;
         upd = now;
      end
   endfunction

   function automatic int count_entries();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) if (t_valid[i]) n++;
      return n;
   endfunction

   // predict one transaction and update the model table
   function automatic rsp_type predict_decision(req_type r);
      rsp_type     res;
      logic [63:0] hi, lo, now, cp, ap, lim, ret, ct, cu, at, au;
      logic [31:0] sc;
      int          e, slot;
      logic [2:0]  dec;
      bit          done;
      hi  = r.addr_is_v6 ? r.addr_high : 64'd0;
      lo  = r.addr_is_v6 ? r.addr_low : {32'd0, r.addr_low[31:0]};
      sc  = r.addr_is_v6 ? r.scope_tag : 32'd0;
      now = {16'd0, r.now_tick};
      cp  = eff_per(m_conn_per);
      ap  = eff_per(m_auth_per);
      lim = (m_max_track > TABLE_ENTRIES) ? TABLE_ENTRIES : m_max_track;
      ret = (cp > ap) ? cp : ap;
      dec = DEC_ALLOWED;
      done = 1'b0;
      e = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (e < 0 && t_valid[i] && t_key[i].addr_high == hi && t_key[i].addr_low == lo &&
             t_key[i].addr_is_v6 == r.addr_is_v6 && t_key[i].scope_tag == sc)
            e = i;
      if (r.opcode == OP_ADMIT) begin
         if (e < 0) begin
            if (m_total >= m_max_sess) begin
               dec = DEC_GLOBAL; done = 1'b1;
            end else begin
               if (count_entries() >= lim)
                  for (int i = 0; i < TABLE_ENTRIES; i++)
                     if (t_valid[i] && t_sess[i] == 0 && now >= t_seen[i] &&
                         now - t_seen[i] >= ret)
                        t_valid[i] = 1'b0;
               slot = -1;
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (slot < 0 && !t_valid[i]) slot = i;
               if (count_entries() >= lim || slot < 0) begin
                  dec = DEC_TABLE_FULL; done = 1'b1;
               end else begin
                  e = slot;
                  t_valid[e] = 1'b1;
                  t_key[e] = '{OP_ADMIT, hi, lo, r.addr_is_v6, sc, 48'd0};
                  t_sess[e] = 0;
                  t_ctok[e] = (m_conn_cnt * cp) & 64'hFFFF_FFFF_FFFF;
                  t_cupd[e] = now;
                  t_atok[e] = (m_auth_cnt * ap) & 64'hFFFF_FFFF_FFFF;
                  t_aupd[e] = now;
               end
            end
         end
         if (!done) begin
            t_seen[e] = now;
            ct = t_ctok[e]; cu = t_cupd[e];
            refill_bucket(ct, cu, m_conn_cnt, cp, now);
            if (ct < cp) dec = DEC_CONN_RATE;
            else begin
               ct = ct - cp;
               at = t_atok[e]; au = t_aupd[e];
               refill_bucket(at, au, m_auth_cnt, ap, now);
               t_atok[e] = at; t_aupd[e] = au;
               if (at < ap) dec = DEC_AUTH_RATE;
               else if (m_total >= m_max_sess) dec = DEC_GLOBAL;
               else if (t_sess[e] >= m_max_per_src) dec = DEC_PER_SOURCE;
               else begin
                  t_sess[e] = (t_sess[e] + 1) & 64'hFFFF;
                  m_total = (m_total + 1) & 64'hFFFF;
               end
            end
            t_ctok[e] = ct; t_cupd[e] = cu;
         end
      end else if (e >= 0) begin
         if (r.opcode == OP_RELEASE) begin
            if (t_sess[e] != 0) begin
               t_sess[e]--;
               if (m_total != 0) m_total--;
               t_seen[e] = now;
            end
         end else begin
            at = t_atok[e]; au = t_aupd[e];
            refill_bucket(at, au, m_auth_cnt, ap, now);
            if (r.opcode == OP_DENIED_AUTH && at >= ap) at = at - ap;
            else at = 0;
            t_atok[e] = at; t_aupd[e] = au;
            t_seen[e] = now;
         end
      end
      res.decision = dec;
      res.source_known = (e >= 0 && t_valid[e]);
      return res;
   endfunction

   // driver: present pending transactions at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_fired) begin
         // hold
      end else begin
         if (req_chan.valid) void'(pending_reqs.pop_front());
         if (tx_gap > 0) begin
            tx_gap--;
            req_chan.valid <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 19) == 0) begin
            tx_gap = $urandom_range(1, 12);
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_chan.valid      <= 1'b1;
            req_chan.opcode     <= pending_reqs[0].opcode;
            req_chan.addr_high  <= pending_reqs[0].addr_high;
            req_chan.addr_low   <= pending_reqs[0].addr_low;
            req_chan.addr_is_v6 <= pending_reqs[0].addr_is_v6;
            req_chan.scope_tag  <= pending_reqs[0].scope_tag;
            req_chan.now_tick   <= pending_reqs[0].now_tick;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (rx_gap > 0) begin
         rx_gap--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 19) == 0) begin
         rx_gap = $urandom_range(1, 12);
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= 1'b1;
   end

   // monitor: predict at request acceptance, check at response acceptance
   always @(posedge clock) begin
      rsp_type got, want;
      req_type acc;
      req_fired = !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            acc.opcode     = op_type'(req_chan.opcode);
            acc.addr_high  = req_chan.addr_high;
            acc.addr_low   = req_chan.addr_low;
            acc.addr_is_v6 = req_chan.addr_is_v6;
            acc.scope_tag  = req_chan.scope_tag;
            acc.now_tick   = req_chan.now_tick;
            expected_rsps.push_back(predict_decision(acc));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.decision = rsp_chan.decision;
            got.source_known = rsp_chan.source_known;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response dec=%0d known=%0b", $time,
                        got.decision, got.source_known);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.decision !== want.decision) begin
                  $display("%0t: decision mismatch expected %0d actual %0d", $time,
                           want.decision, got.decision);
                  error_count++;
               end
               if (got.source_known !== want.source_known) begin
                  $display("%0t: source_known mismatch expected %0b actual %0b", $time,
                           want.source_known, got.source_known);
                  error_count++;
               end
            end
         end
      end
   end

   // register write while idle; model follows at the same time
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_MAX_SESSIONS:     m_max_sess = val & 32'hFFFF;
         CSR_MAX_PER_SOURCE:   m_max_per_src = val & 32'hFFFF;
         CSR_MAX_TRACKED:      m_max_track = val & 32'h7F;
         CSR_CONN_RATE_COUNT:  m_conn_cnt = val & 32'hFFFF;
         CSR_CONN_RATE_PERIOD: m_conn_per = val;
         CSR_AUTH_RATE_COUNT:  m_auth_cnt = val & 32'hFFFF;
         CSR_AUTH_RATE_PERIOD: m_auth_per = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_chan.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_type make_req(op_type op, logic [63:0] hi, logic [63:0] lo,
                                        logic v6, logic [31:0] sc, logic [47:0] now);
      req_type r;
      r = '{op, hi, lo, v6, sc, now};
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random source: mostly from a small pool so entries get reused
   function automatic req_type rand_source();
      req_type r;
      if (addr_pool.size() > 0 && $urandom_range(0, 3) != 0)
         r = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      else begin
         r.addr_is_v6 = $urandom_range(0, 1);
         r.addr_high = rand64();
         r.addr_low = rand64();
         r.scope_tag = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
         addr_pool.push_back(r);
         if (addr_pool.size() > 24) void'(addr_pool.pop_front());
      end
      // IPv4 noise in ignored bits keeps the key the same
      if (!r.addr_is_v6 && $urandom_range(0, 3) == 0) begin
         r.addr_high = rand64();
         r.scope_tag = $urandom;
         r.addr_low[63:32] = $urandom;
      end
      return r;
   endfunction

   logic [47:0] clock_now;

   task automatic random_phase(int n, int step_max);
      req_type r;
      int      pick;
      for (int k = 0; k < n; k++) begin
         r = rand_source();
         pick = $urandom_range(0, 9);
         if (pick < 5) r.opcode = OP_ADMIT;
         else if (pick < 8) r.opcode = OP_RELEASE;
         else if (pick < 9) r.opcode = OP_DENIED_AUTH;
         else r.opcode = OP_EXHAUST_AUTH;
         if ($urandom_range(0, 15) == 0) clock_now = clock_now - $urandom_range(0, step_max);
         else clock_now = clock_now + $urandom_range(0, step_max);
         r.now_tick = clock_now;
         pending_reqs.push_back(r);
      end
   endtask

   // stimulus
   initial begin
      model_reset();
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.addr_high = '0;
      req_chan.addr_low = '0;
      req_chan.addr_is_v6 = 1'b0;
      req_chan.scope_tag = '0;
      req_chan.now_tick = '0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: small limits so edges are reached quickly
      write_reg(CSR_MAX_SESSIONS, 3);
      write_reg(CSR_MAX_PER_SOURCE, 2);
      write_reg(CSR_MAX_TRACKED, 2);
      write_reg(CSR_CONN_RATE_COUNT, 2);
      write_reg(CSR_CONN_RATE_PERIOD, 100);
      write_reg(CSR_AUTH_RATE_COUNT, 1);
      write_reg(CSR_AUTH_RATE_PERIOD, 50);
      pending_reqs.push_back(make_req(OP_RELEASE, 0, 32'h0A000001, 0, 0, 10));
      pending_reqs.push_back(make_req(OP_ADMIT, 64'hFFFF_0000, 64'hDEAD_0000_0A00_0001,
                                      0, 32'hFFFF_FFFF, 10));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'h0A000001, 0, 0, 10));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'h0A000001, 0, 0, 10));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'h0A000001, 0, 0, 200));
      pending_reqs.push_back(make_req(OP_ADMIT, '1, '1, 1, '1, 200));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 0, 1, 0, 200));
      pending_reqs.push_back(make_req(OP_DENIED_AUTH, '1, '1, 1, '1, 210));
      pending_reqs.push_back(make_req(OP_DENIED_AUTH, '1, '1, 1, '1, 211));
      pending_reqs.push_back(make_req(OP_ADMIT, '1, '1, 1, '1, 212));
      pending_reqs.push_back(make_req(OP_EXHAUST_AUTH, 0, 32'h0A000001, 0, 0, 300));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'h0A000001, 0, 0, 301));
      pending_reqs.push_back(make_req(OP_RELEASE, 0, 32'h0A000001, 0, 0, 302));
      pending_reqs.push_back(make_req(OP_RELEASE, 0, 32'h0A000001, 0, 0, 303));
      pending_reqs.push_back(make_req(OP_RELEASE, 0, 32'h0A000001, 0, 0, 304));
      pending_reqs.push_back(make_req(OP_RELEASE, '1, '1, 1, '1, 305));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'hC0A80001, 0, 0, 1000));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'hC0A80001, 0, 0, 900));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'hC0A80002, 0, 0, 48'hFFFF_FFFF_FFFF));
      // the sender waits here until every response has come
      wait_drained();

      // zero registers and extremes
      write_reg(CSR_MAX_TRACKED, 0);
      write_reg(CSR_CONN_RATE_COUNT, 0);
      write_reg(CSR_CONN_RATE_PERIOD, 0);
      write_reg(CSR_MAX_SESSIONS, 0);
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'h01020304, 0, 0, 5));
      wait_drained();
      write_reg(CSR_MAX_SESSIONS, 16'hFFFF);
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'h01020305, 0, 0, 6));
      pending_reqs.push_back(make_req(OP_ADMIT, 0, 32'hC0A80001, 0, 0, 7));
      wait_drained();

      // random phases over several settings
      clock_now = 1000;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_MAX_SESSIONS, 8);  write_reg(CSR_MAX_PER_SOURCE, 2);
               write_reg(CSR_MAX_TRACKED, 8);   write_reg(CSR_CONN_RATE_COUNT, 3);
               write_reg(CSR_CONN_RATE_PERIOD, 40); write_reg(CSR_AUTH_RATE_COUNT, 2);
               write_reg(CSR_AUTH_RATE_PERIOD, 30);
            end
            1: begin
               write_reg(CSR_MAX_SESSIONS, 16'hFFFF); write_reg(CSR_MAX_PER_SOURCE, 16'hFFFF);
               write_reg(CSR_MAX_TRACKED, 7'h7F);      write_reg(CSR_CONN_RATE_COUNT, 16'hFFFF);
               write_reg(CSR_CONN_RATE_PERIOD, 32'hFFFF_FFFF);
               write_reg(CSR_AUTH_RATE_COUNT, 16'hFFFF);
               write_reg(CSR_AUTH_RATE_PERIOD, 32'hFFFF_FFFF);
            end
            2: begin
               write_reg(CSR_MAX_SESSIONS, 1);  write_reg(CSR_MAX_PER_SOURCE, 1);
               write_reg(CSR_MAX_TRACKED, 1);   write_reg(CSR_CONN_RATE_COUNT, 1);
               write_reg(CSR_CONN_RATE_PERIOD, 1); write_reg(CSR_AUTH_RATE_COUNT, 1);
               write_reg(CSR_AUTH_RATE_PERIOD, 1);
            end
            3: begin
               write_reg(CSR_MAX_SESSIONS, 30); write_reg(CSR_MAX_PER_SOURCE, 3);
               write_reg(CSR_MAX_TRACKED, 64);  write_reg(CSR_CONN_RATE_COUNT, 4);
               write_reg(CSR_CONN_RATE_PERIOD, 200); write_reg(CSR_AUTH_RATE_COUNT, 3);
               write_reg(CSR_AUTH_RATE_PERIOD, 500);
            end
            default: begin
               write_reg(CSR_MAX_SESSIONS, 64); write_reg(CSR_MAX_PER_SOURCE, 4);
               write_reg(CSR_MAX_TRACKED, 12);  write_reg(CSR_CONN_RATE_COUNT, 10);
               write_reg(CSR_CONN_RATE_PERIOD, 100); write_reg(CSR_AUTH_RATE_COUNT, 5);
               write_reg(CSR_AUTH_RATE_PERIOD, 100);
            end
         endcase
         if (ph == 4) idle_enable = 1'b0;
         random_phase(200, (ph == 1) ? 2000 : 60);
         wait_drained();
      end
      if (error_count == 0) $display("tb_per_source_admission_rate_limiter passed");
      else $display("tb_per_source_admission_rate_limiter failed");
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("tb_per_source_admission_rate_limiter failed");
      $finish;
   end

endmodule
`default_nettype wire
